// ===== rtl/variable_record_ring_buffer_top_macros.svh =====
// Assertion macros for the variable record ring buffer.
// Each macro is one labelled concurrent assertion clocked on clk and
// disabled while rst is high. Synthesis builds define SYNTH and get nothing.
`ifndef VARIABLE_RECORD_RING_BUFFER_TOP_MACROS_SVH
`define VARIABLE_RECORD_RING_BUFFER_TOP_MACROS_SVH

`ifndef SYNTH

`define VRRB_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`define VRRB_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define VRRB_ASSERT_IMP(lbl, pre, post, msg)

`define VRRB_ASSERT_NXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/vrrb_pkg.sv =====
// ----------------------------------------------------------------------------
// vrrb_pkg
// Types and constants of the variable record ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package vrrb_pkg;

  localparam int CAPACITY = 4096;
  localparam int RING_W   = $clog2(CAPACITY);
  localparam int SLOTS    = CAPACITY / 8;
  localparam int SLOT_W   = RING_W - 3;
  localparam int POS_W    = 64;
  localparam int OCC_W    = 13;
  localparam int HLEN_W   = 14;
  localparam int KIND_W   = 32;

  localparam logic [OCC_W-1:0]  CAP_BYTES = OCC_W'(CAPACITY);
  localparam logic [12:0]       MAX_CLAIM = 13'(CAPACITY - 8);
  localparam logic [KIND_W-1:0] PAD_KIND  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CLAIM  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TOO_LONG = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_BAD_TYPE = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // one header word per 8-byte slot: record type and length incl. header
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [HLEN_W-1:0] len;
  } hdr_t;

endpackage

`default_nettype wire

// ===== rtl/variable_record_ring_buffer_top.sv =====
// Steps, input beat to result beat: commit goes to done; claim goes through occ, claim, pos, prod and done
// (occ, claim, done when out of space; done alone when too long); read goes through raddr, rdata and done,
// and raddr, rdata again when a padding record is skipped; op 3 goes to done. Only one beat is in flight:
// a new input beat is taken only once the last result is in the output register. A 64-bit adder shared by
// the sequencer and the registered header read set these steps. After rst the header memory is cleared one
// slot a cycle (all 512 slots) and no input beat is taken until that pass is done.
`default_nettype none
`include "variable_record_ring_buffer_top_macros.svh"

// ----------------------------------------------------------------------------
// variable_record_ring_buffer_top
// Claim, commit and read of 8-byte aligned records in a byte ring.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer_top
  import vrrb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // length[12:0], hdr_index[24:13], type_id[56:25], zero fill above
  input  wire logic [63:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // position[63:0], record_index[75:64], padded[76], out_type_id[107:77],
  // content_index[119:108], content_length[131:120], occupied_bytes[144:132]
  output logic [151:0]      m_axis_tdata,
  // status[2:0]
  output logic [2:0]        m_axis_tuser
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_OCC, S_CLAIM, S_POS, S_PROD, S_RADDR, S_RDATA, S_DONE
  } state_t;

  state_t state;

  logic [SLOT_W-1:0] clr_idx;
  logic [POS_W-1:0]  prod;
  logic [POS_W-1:0]  cons;
  logic              skipped;

  // claim working registers
  logic [12:0]       len_r;
  logic              occ_neg;
  logic              occ_le;
  logic [OCC_W-1:0]  occ_lo;
  logic [OCC_W-1:0]  pad_r;
  logic [OCC_W-1:0]  req_r;

  // result registers
  status_t           res_status;
  logic [POS_W-1:0]  res_pos;
  logic [11:0]       res_rec_idx;
  logic              res_padded;
  logic [30:0]       res_type;
  logic [11:0]       res_cidx;
  logic [11:0]       res_clen;

  // input fields
  op_t               in_op;
  logic [12:0]       in_len;
  logic [11:0]       in_idx;
  logic [31:0]       in_type;
  logic              type_ok;

  assign in_op   = op_t'(s_axis_tuser);
  assign in_len  = s_axis_tdata[12:0];
  assign in_idx  = s_axis_tdata[24:13];
  assign in_type = s_axis_tdata[56:25];
  assign type_ok = (in_type != '0) && !in_type[31];

  assign s_axis_tready = (state == S_IDLE);

  // header memory
  hdr_t              mem [SLOTS];
  hdr_t              rdata;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  hdr_t              wdata;

  // claim decision
  logic [13:0]       req_w;
  logic [OCC_W-1:0]  req;
  logic [OCC_W-1:0]  until_end;
  logic              fits;
  logic              wrap;
  logic              claim_ok;

  assign req_w     = ({1'b0, len_r} + 14'd15) & ~14'd7;
  assign req       = req_w[OCC_W-1:0];
  assign until_end = CAP_BYTES - {1'b0, prod[RING_W-1:0]};
  assign fits      = occ_neg || (occ_le && (req <= CAP_BYTES - occ_lo));
  assign wrap      = req > until_end;
  assign claim_ok  = fits && !(wrap && (req > {1'b0, cons[RING_W-1:0]}));

  // read decision
  logic              rd_pad;
  logic              rd_empty;
  logic [14:0]       rd_al;

  assign rd_pad   = (rdata.kind == PAD_KIND);
  assign rd_empty = (rdata.len == '0) || (rd_pad && skipped);
  assign rd_al    = ({1'b0, rdata.len} + 15'd7) & ~15'd7;

  // shared 64-bit adder
  logic [POS_W-1:0]  add_a;
  logic [POS_W-1:0]  add_b;
  logic              add_cin;
  logic [POS_W-1:0]  sum;

  always_comb begin
    add_a   = prod;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state)
      S_OCC: begin
        add_b   = ~cons;
        add_cin = 1'b1;
      end
      S_POS: add_b = {{(POS_W-OCC_W){1'b0}}, pad_r};
      S_PROD: begin
        add_a = res_pos;
        add_b = {{(POS_W-OCC_W){1'b0}}, req_r};
      end
      S_RDATA: begin
        add_a = cons;
        add_b = {{(POS_W-15){1'b0}}, rd_al};
      end
      default: ;
    endcase
  end

  assign sum = add_a + add_b + {{(POS_W-1){1'b0}}, add_cin};

  // memory write port
  always_comb begin
    we    = 1'b0;
    waddr = clr_idx;
    wdata = '0;
    unique case (state)
      S_CLEAR: we = 1'b1;
      S_IDLE: begin
        if (s_axis_tvalid && in_op == OP_COMMIT && type_ok) begin
          we         = 1'b1;
          waddr      = in_idx[RING_W-1:3];
          wdata.kind = in_type;
          wdata.len  = {1'b0, in_len} + 14'd8;
        end
      end
      S_CLAIM: begin
        if (claim_ok && wrap) begin
          we         = 1'b1;
          waddr      = prod[RING_W-1:3];
          wdata.kind = PAD_KIND;
          wdata.len  = {1'b0, until_end};
        end
      end
      S_RDATA: begin
        // consumed header is zeroed
        if (!rd_empty) begin
          we    = 1'b1;
          waddr = cons[RING_W-1:3];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cons[RING_W-1:3]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      prod          <= '0;
      cons          <= '0;
      skipped       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // done state decides tvalid itself
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_W'(SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_status  <= ST_OK;
            res_pos     <= '0;
            res_rec_idx <= '0;
            res_padded  <= 1'b0;
            res_type    <= '0;
            res_cidx    <= '0;
            res_clen    <= '0;
            len_r       <= in_len;
            skipped     <= 1'b0;
            unique case (in_op)
              OP_CLAIM: begin
                if (in_len > MAX_CLAIM) begin
                  res_status <= ST_TOO_LONG;
                  state      <= S_DONE;
                end else begin
                  state <= S_OCC;
                end
              end
              OP_COMMIT: begin
                if (!type_ok) begin
                  res_status <= ST_BAD_TYPE;
                end
                state <= S_DONE;
              end
              OP_READ: state <= S_RADDR;
              OP_NONE: state <= S_DONE;
            endcase
          end
        end
        S_OCC: begin
          // wrapped difference counts as ample space
          occ_neg <= sum[POS_W-1];
          occ_le  <= (sum[POS_W-1:OCC_W] == '0) && (sum[OCC_W-1:0] <= CAP_BYTES);
          occ_lo  <= sum[OCC_W-1:0];
          state   <= S_CLAIM;
        end
        S_CLAIM: begin
          if (!claim_ok) begin
            res_status <= ST_NO_SPACE;
            state      <= S_DONE;
          end else begin
            pad_r       <= wrap ? until_end : '0;
            req_r       <= req;
            res_rec_idx <= wrap ? '0 : prod[RING_W-1:0];
            res_padded  <= wrap;
            state       <= S_POS;
          end
        end
        S_POS: begin
          res_pos <= sum;
          state   <= S_PROD;
        end
        S_PROD: begin
          prod  <= sum;
          state <= S_DONE;
        end
        S_RADDR: state <= S_RDATA;
        S_RDATA: begin
          if (rd_empty) begin
            res_status <= ST_EMPTY;
            state      <= S_DONE;
          end else if (rd_pad) begin
            // skip one padding record and look again
            cons    <= sum;
            skipped <= 1'b1;
            state   <= S_RADDR;
          end else begin
            cons     <= sum;
            res_type <= rdata.kind[30:0];
            res_cidx <= cons[RING_W-1:0] + 12'd8;
            res_clen <= rdata.len[11:0] - 12'd8;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= res_status;
            m_axis_tdata  <= {7'd0, prod[OCC_W-1:0] - cons[OCC_W-1:0], res_clen,
                              res_cidx, res_type, res_padded, res_rec_idx, res_pos};
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  `VRRB_ASSERT_IMP(a_prod_only_in_claim, !$past(rst) && $past(state) != S_PROD, $stable(prod), "producer moved outside a claim")
  `VRRB_ASSERT_IMP(a_pos_aligned, 1'b1, prod[2:0] == 3'd0 && cons[2:0] == 3'd0, "position not 8-byte aligned")
  `VRRB_ASSERT_IMP(a_result_from_done, $rose(m_axis_tvalid), $past(state) == S_DONE, "result beat not from done state")
  `VRRB_ASSERT_IMP(a_pad_at_start, m_axis_tvalid && m_axis_tdata[76], m_axis_tdata[75:64] == 12'd0, "padded claim not at ring start")
  `VRRB_ASSERT_NXT(a_clear_no_result, state == S_CLEAR, state == S_CLEAR || state == S_IDLE, "clearing pass left early")

endmodule

`default_nettype wire
